// ===== src/mcs_pkg.sv =====
`default_nettype none
package mcs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  localparam int DIFF_W  = WORD_BITS + 1;
  localparam int QUO_W   = DIFF_W + FRAC_BITS;
  localparam int RAT_W   = FRAC_BITS + 4;
  localparam int NUM2_W  = WORD_BITS + FRAC_BITS;
  localparam int HEAD_W  = NUM2_W - RAT_W;
  localparam int HI_W    = WORD_BITS - FRAC_BITS;
  localparam int PSUM_W  = QUO_W;
  localparam int COEF_W  = QUO_W + 3;
  localparam int LIN_W   = RAT_W + 2;
  localparam int QUAD_W  = 2 * LIN_W;
  localparam int MID_W   = WORD_BITS + 4;

  localparam logic [RAT_W-1:0] RAT_CLAMP = RAT_W'(8 << FRAC_BITS);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOTMONO = 2'd1;
  localparam logic [1:0] ST_DEGEN   = 2'd2;

  typedef struct packed {
    logic signed [DIFF_W-1:0]    dx;
    logic signed [DIFF_W-1:0]    dy;
    logic signed [WORD_BITS-1:0] y0;
    logic signed [WORD_BITS-1:0] s0;
    logic signed [WORD_BITS-1:0] s1;
    logic [WORD_BITS-1:0]        abs_s0;
    logic [WORD_BITS-1:0]        abs_s1;
    logic                        degen;
    logic                        agree;
    logic                        last;
  } mcs_item_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] cubic;
    logic signed [WORD_BITS-1:0] square;
    logic signed [WORD_BITS-1:0] linear;
    logic signed [WORD_BITS-1:0] konst;
    logic [1:0]                  status;
    logic                        flat;
    logic                        last;
  } mcs_res_t;

  function automatic logic signed [WORD_BITS-1:0] sat_word(logic signed [COEF_W-1:0] v);
    logic [COEF_W-WORD_BITS:0] top;
    top = v[COEF_W-1:WORD_BITS-1];
    if (top == '0 || top == '1) begin
      return v[WORD_BITS-1:0];
    end else if (v[COEF_W-1]) begin
      return {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(WORD_BITS-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/monotone_cubic_spline_coeffs.sv =====
`default_nettype none
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  x, y, end slopes of one interval, last flag
// out_     output     out_valid/out_stall four coefficients, status, flattened, last
//
// One interval per cycle sustained while in_stall is low.
// The path runs through the front stage, the 49-step slope divider, the 20-step ratio divider and the evaluator.
// rst_n is synchronous; it clears all valid bits and the output skid.
// Stall is taken from a registered skid flag, so a stalled output still takes
// one more transaction before in_stall rises.
module monotone_cubic_spline_coeffs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] in_x_left,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] in_x_right,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] in_y_left,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] in_y_right,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] in_slope_left,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] in_slope_right,
  input  wire logic                                in_last_interval,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [mcs_pkg::WORD_BITS-1:0]     out_coef_cubic,
  output logic signed [mcs_pkg::WORD_BITS-1:0]     out_coef_square,
  output logic signed [mcs_pkg::WORD_BITS-1:0]     out_coef_linear,
  output logic signed [mcs_pkg::WORD_BITS-1:0]     out_coef_const,
  output logic [1:0]                               out_status,
  output logic                                     out_flattened,
  output logic                                     out_last_out
);
  import mcs_pkg::*;

  logic              en;
  logic              f_vld, s_vld, r_vld, p_vld;
  mcs_item_t         f_item, s_item, r_item;
  logic [QUO_W-1:0]  f_num, s_quo;
  logic [DIFF_W-1:0] f_dvs;
  logic [RAT_W-1:0]  r_alpha, r_beta;
  mcs_res_t          p_res;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_full_r, skid_full_nxt;
  mcs_res_t  out_res_r, out_res_nxt;
  mcs_res_t  skid_res_r, skid_res_nxt;
  logic      take;

  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  mcs_front u_front (
    .clk, .rst_n, .en,
    .in_vld   (in_valid),
    .x0       (in_x_left),
    .x1       (in_x_right),
    .y0       (in_y_left),
    .y1       (in_y_right),
    .s0       (in_slope_left),
    .s1       (in_slope_right),
    .last     (in_last_interval),
    .out_vld  (f_vld),
    .out_item (f_item),
    .out_num  (f_num),
    .out_dvs  (f_dvs)
  );

  mcs_slope_div u_sdiv (
    .clk, .rst_n, .en,
    .in_vld   (f_vld),
    .in_item  (f_item),
    .in_num   (f_num),
    .in_dvs   (f_dvs),
    .out_vld  (s_vld),
    .out_item (s_item),
    .out_quo  (s_quo)
  );

  mcs_ratio_div u_rdiv (
    .clk, .rst_n, .en,
    .in_vld    (s_vld),
    .in_item   (s_item),
    .in_quo    (s_quo),
    .out_vld   (r_vld),
    .out_item  (r_item),
    .out_alpha (r_alpha),
    .out_beta  (r_beta)
  );

  mcs_eval u_eval (
    .clk, .rst_n, .en,
    .in_vld   (r_vld),
    .in_item  (r_item),
    .in_alpha (r_alpha),
    .in_beta  (r_beta),
    .out_vld  (p_vld),
    .out_res  (p_res)
  );

  always_comb begin
    take          = out_valid_r && !out_stall;
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_res_nxt   = out_res_r;
    skid_res_nxt  = skid_res_r;
    if (skid_full_r) begin
      if (take) begin
        out_res_nxt   = skid_res_r;
        out_valid_nxt = 1'b1;
        skid_full_nxt = 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_nxt = p_vld;
      out_res_nxt   = p_res;
    end else if (p_vld) begin
      skid_full_nxt = 1'b1;
      skid_res_nxt  = p_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_coef_cubic  = out_res_r.cubic;
  assign out_coef_square = out_res_r.square;
  assign out_coef_linear = out_res_r.linear;
  assign out_coef_const  = out_res_r.konst;
  assign out_status      = out_res_r.status;
  assign out_flattened   = out_res_r.flat;
  assign out_last_out    = out_res_r.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds a transaction while output is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_coef_cubic == '0 && out_coef_square == '0 && out_coef_linear == '0
       && out_coef_const == '0 && !out_flattened))
    else $error("failed interval carries nonzero coefficients");

  a_flat_terms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flattened) |->
      (out_status == ST_OK && out_coef_cubic == '0 && out_coef_square == '0))
    else $error("flattened result keeps curvature terms");

endmodule
`default_nettype wire

// ===== src/mcs_front.sv =====
`default_nettype none
module mcs_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_vld,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] x0,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] x1,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] y0,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] y1,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] s0,
  input  wire logic signed [mcs_pkg::WORD_BITS-1:0] s1,
  input  wire logic                              last,
  output logic                                   out_vld,
  output mcs_pkg::mcs_item_t                     out_item,
  output logic [mcs_pkg::QUO_W-1:0]              out_num,
  output logic [mcs_pkg::DIFF_W-1:0]             out_dvs
);
  import mcs_pkg::*;

  logic                      vld_r;
  mcs_item_t                 item_r, item_nxt;
  logic [QUO_W-1:0]          num_r, num_nxt;
  logic [DIFF_W-1:0]         dvs_r, dvs_nxt;
  logic signed [DIFF_W-1:0]  dx, dy;
  logic [DIFF_W-1:0]         dy_mag;
  logic                      m_neg;

  always_comb begin
    dx = DIFF_W'(x1) - DIFF_W'(x0);
    dy = DIFF_W'(y1) - DIFF_W'(y0);
    m_neg = dx[DIFF_W-1] ^ dy[DIFF_W-1];
    dy_mag = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    dvs_nxt = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    num_nxt = {dy_mag, {FRAC_BITS{1'b0}}};
    item_nxt.dx = dx;
    item_nxt.dy = dy;
    item_nxt.y0 = y0;
    item_nxt.s0 = s0;
    item_nxt.s1 = s1;
    item_nxt.abs_s0 = s0[WORD_BITS-1] ? WORD_BITS'(-s0) : WORD_BITS'(s0);
    item_nxt.abs_s1 = s1[WORD_BITS-1] ? WORD_BITS'(-s1) : WORD_BITS'(s1);
    item_nxt.degen = (dx == '0);
    item_nxt.agree = ((s0 == '0) || (s0[WORD_BITS-1] == m_neg))
                  && ((s1 == '0) || (s1[WORD_BITS-1] == m_neg));
    item_nxt.last = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
      num_r  <= num_nxt;
      dvs_r  <= dvs_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;
  assign out_num  = num_r;
  assign out_dvs  = dvs_r;

endmodule
`default_nettype wire

// ===== src/mcs_slope_div.sv =====
`default_nettype none
module mcs_slope_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_vld,
  input  wire mcs_pkg::mcs_item_t            in_item,
  input  wire logic [mcs_pkg::QUO_W-1:0]     in_num,
  input  wire logic [mcs_pkg::DIFF_W-1:0]    in_dvs,
  output logic                               out_vld,
  output mcs_pkg::mcs_item_t                 out_item,
  output logic [mcs_pkg::QUO_W-1:0]          out_quo
);
  import mcs_pkg::*;

  typedef struct packed {
    logic [DIFF_W-1:0] rem;
    logic [QUO_W-1:0]  nq;
    logic [DIFF_W-1:0] dvs;
  } sdiv_t;

  logic [QUO_W-1:0] vld_r;
  mcs_item_t        item_r  [QUO_W];
  sdiv_t            div_r   [QUO_W];
  sdiv_t            div_nxt [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-2:0], in_vld};
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    sdiv_t             src;
    mcs_item_t         item_src;
    logic [DIFF_W:0]   trial;
    logic [DIFF_W:0]   diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src      = '{rem: '0, nq: in_num, dvs: in_dvs};
      assign item_src = in_item;
    end else begin : g_rest
      assign src      = div_r[k-1];
      assign item_src = item_r[k-1];
    end

    always_comb begin
      trial = {src.rem, src.nq[QUO_W-1]};
      diff  = trial - {1'b0, src.dvs};
      ge    = (trial >= {1'b0, src.dvs});
      div_nxt[k].rem = ge ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
      div_nxt[k].nq  = {src.nq[QUO_W-2:0], ge};
      div_nxt[k].dvs = src.dvs;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k]  <= div_nxt[k];
        item_r[k] <= item_src;
      end
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_item = item_r[QUO_W-1];
  assign out_quo  = div_r[QUO_W-1].nq;

endmodule
`default_nettype wire

// ===== src/mcs_ratio_div.sv =====
`default_nettype none
module mcs_ratio_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_vld,
  input  wire mcs_pkg::mcs_item_t           in_item,
  input  wire logic [mcs_pkg::QUO_W-1:0]    in_quo,
  output logic                              out_vld,
  output mcs_pkg::mcs_item_t                out_item,
  output logic [mcs_pkg::RAT_W-1:0]         out_alpha,
  output logic [mcs_pkg::RAT_W-1:0]         out_beta
);
  import mcs_pkg::*;

  typedef struct packed {
    logic [QUO_W-1:0] rem;
    logic [RAT_W-1:0] nq;
    logic             clamp;
  } lane_t;

  typedef struct packed {
    lane_t            a;
    lane_t            b;
    logic [QUO_W-1:0] dvs;
  } rdiv_t;

  function automatic lane_t lane_setup(logic [WORD_BITS-1:0] mag, logic [QUO_W-1:0] q);
    lane_t             l;
    logic [NUM2_W-1:0] n2;
    n2 = {mag, {FRAC_BITS{1'b0}}};
    l.rem   = QUO_W'(n2[NUM2_W-1:RAT_W]);
    l.nq    = n2[RAT_W-1:0];
    l.clamp = (q[QUO_W-1:HEAD_W] == '0) && ({q[HEAD_W-1:0], {RAT_W{1'b0}}} <= n2);
    return l;
  endfunction

  function automatic lane_t lane_step(lane_t l, logic [QUO_W-1:0] dvs);
    lane_t          o;
    logic [QUO_W:0] trial;
    logic [QUO_W:0] diff;
    logic           ge;
    trial   = {l.rem, l.nq[RAT_W-1]};
    diff    = trial - {1'b0, dvs};
    ge      = (trial >= {1'b0, dvs});
    o.rem   = ge ? diff[QUO_W-1:0] : trial[QUO_W-1:0];
    o.nq    = {l.nq[RAT_W-2:0], ge};
    o.clamp = l.clamp;
    return o;
  endfunction

  logic [RAT_W:0] vld_r;
  mcs_item_t      item_r  [RAT_W+1];
  rdiv_t          div_r   [RAT_W+1];
  rdiv_t          div_nxt [RAT_W+1];
  mcs_item_t      set_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RAT_W-1:0], in_vld};
    end
  end

  always_comb begin
    set_item        = in_item;
    set_item.degen  = in_item.degen || (in_quo == '0);
    div_nxt[0].a    = lane_setup(in_item.abs_s0, in_quo);
    div_nxt[0].b    = lane_setup(in_item.abs_s1, in_quo);
    div_nxt[0].dvs  = in_quo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0]  <= div_nxt[0];
      item_r[0] <= set_item;
    end
  end

  for (genvar k = 1; k <= RAT_W; k++) begin : g_step
    always_comb begin
      div_nxt[k].a   = lane_step(div_r[k-1].a, div_r[k-1].dvs);
      div_nxt[k].b   = lane_step(div_r[k-1].b, div_r[k-1].dvs);
      div_nxt[k].dvs = div_r[k-1].dvs;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k]  <= div_nxt[k];
        item_r[k] <= item_r[k-1];
      end
    end
  end

  assign out_vld   = vld_r[RAT_W];
  assign out_item  = item_r[RAT_W];
  assign out_alpha = (div_r[RAT_W].a.clamp || div_r[RAT_W].a.nq > RAT_CLAMP)
                     ? RAT_CLAMP : div_r[RAT_W].a.nq;
  assign out_beta  = (div_r[RAT_W].b.clamp || div_r[RAT_W].b.nq > RAT_CLAMP)
                     ? RAT_CLAMP : div_r[RAT_W].b.nq;

endmodule
`default_nettype wire

// ===== src/mcs_eval.sv =====
`default_nettype none
module mcs_eval (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_vld,
  input  wire mcs_pkg::mcs_item_t         in_item,
  input  wire logic [mcs_pkg::RAT_W-1:0]  in_alpha,
  input  wire logic [mcs_pkg::RAT_W-1:0]  in_beta,
  output logic                            out_vld,
  output mcs_pkg::mcs_res_t               out_res
);
  import mcs_pkg::*;

  localparam logic [LIN_W-1:0] TWO_ONE   = LIN_W'(2 << FRAC_BITS);
  localparam logic [LIN_W-1:0] THREE_ONE = LIN_W'(3 << FRAC_BITS);
  localparam logic signed [LIN_W-1:0] THREE_S = LIN_W'(3 << FRAC_BITS);
  localparam logic signed [LIN_W-1:0] SIX_S   = LIN_W'(6 << FRAC_BITS);
  localparam int PH_W = DIFF_W + HI_W;
  localparam int PL_W = DIFF_W + FRAC_BITS + 1;

  logic [4:0] vld_r;

  // stage 1: linear tests and products
  logic [LIN_W-1:0]          sum_ab, sum_a2b, sum_2ab;
  logic signed [LIN_W-1:0]   al_s, be_s, bm3, bm6;
  logic [3:0]                lin_r, lin_nxt;
  logic signed [QUAD_W-1:0]  sqa_r, sqa_nxt, crs_r, crs_nxt, sqb_r, sqb_nxt;
  logic signed [PH_W-1:0]    ph0_r, ph0_nxt, ph1_r, ph1_nxt;
  logic signed [PL_W-1:0]    pl0_r, pl0_nxt, pl1_r, pl1_nxt;
  mcs_item_t                 it1_r;

  // stage 2: quadratic test, status, end products
  logic signed [QUAD_W-1:0]  quad;
  logic                      ok;
  logic [1:0]                st2_r, st2_nxt;
  logic signed [PSUM_W-1:0]  p0_r, p0_nxt, p1_r, p1_nxt;
  mcs_item_t                 it2_r;

  // stage 3: raw coefficients
  logic signed [COEF_W-1:0]  p0e, p1e, dye;
  logic signed [COEF_W-1:0]  araw_r, araw_nxt, braw_r, braw_nxt, craw_r, craw_nxt;
  logic [1:0]                st3_r;
  logic signed [WORD_BITS-1:0] y3_r;
  logic                      last3_r;

  // stage 4: saturated coefficients
  logic signed [WORD_BITS-1:0] a4_r, b4_r, c4_r, d4_r;
  logic [1:0]                st4_r;
  logic                      last4_r;

  // stage 5: midpoint test
  logic signed [MID_W-1:0]   ae, be5, ce, de, curv, midv;
  logic                      flat;
  mcs_res_t                  res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  always_comb begin
    sum_ab  = {2'b0, in_alpha} + {2'b0, in_beta};
    sum_a2b = {2'b0, in_alpha} + {1'b0, in_beta, 1'b0};
    sum_2ab = {1'b0, in_alpha, 1'b0} + {2'b0, in_beta};
    lin_nxt[0] = (sum_ab <= TWO_ONE);
    lin_nxt[1] = (sum_a2b > TWO_ONE);
    lin_nxt[2] = (sum_2ab <= THREE_ONE);
    lin_nxt[3] = (sum_a2b <= THREE_ONE);
    al_s = signed'({2'b0, in_alpha});
    be_s = signed'({2'b0, in_beta});
    bm3  = be_s - THREE_S;
    bm6  = be_s - SIX_S;
    sqa_nxt = al_s * al_s;
    crs_nxt = al_s * bm6;
    sqb_nxt = bm3 * bm3;
    ph0_nxt = in_item.dx * signed'(in_item.s0[WORD_BITS-1:FRAC_BITS]);
    ph1_nxt = in_item.dx * signed'(in_item.s1[WORD_BITS-1:FRAC_BITS]);
    pl0_nxt = in_item.dx * signed'({1'b0, in_item.s0[FRAC_BITS-1:0]});
    pl1_nxt = in_item.dx * signed'({1'b0, in_item.s1[FRAC_BITS-1:0]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r <= lin_nxt;
      sqa_r <= sqa_nxt;
      crs_r <= crs_nxt;
      sqb_r <= sqb_nxt;
      ph0_r <= ph0_nxt;
      ph1_r <= ph1_nxt;
      pl0_r <= pl0_nxt;
      pl1_r <= pl1_nxt;
      it1_r <= in_item;
    end
  end

  always_comb begin
    quad = sqa_r + crs_r + sqb_r;
    ok   = it1_r.agree
        && (lin_r[0] || (lin_r[1] && (lin_r[2] || lin_r[3] || quad < 0)));
    if (it1_r.degen) begin
      st2_nxt = ST_DEGEN;
    end else if (!ok) begin
      st2_nxt = ST_NOTMONO;
    end else begin
      st2_nxt = ST_OK;
    end
    p0_nxt = PSUM_W'(ph0_r + (pl0_r >>> FRAC_BITS));
    p1_nxt = PSUM_W'(ph1_r + (pl1_r >>> FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_r <= st2_nxt;
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      it2_r <= it1_r;
    end
  end

  always_comb begin
    p0e = COEF_W'(p0_r);
    p1e = COEF_W'(p1_r);
    dye = COEF_W'(it2_r.dy);
    araw_nxt = p0e + p1e - (dye <<< 1);
    braw_nxt = (dye <<< 1) + dye - (p0e <<< 1) - p1e;
    craw_nxt = p0e;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      araw_r  <= araw_nxt;
      braw_r  <= braw_nxt;
      craw_r  <= craw_nxt;
      st3_r   <= st2_r;
      y3_r    <= it2_r.y0;
      last3_r <= it2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4_r    <= sat_word(araw_r);
      b4_r    <= sat_word(braw_r);
      c4_r    <= sat_word(craw_r);
      d4_r    <= y3_r;
      st4_r   <= st3_r;
      last4_r <= last3_r;
    end
  end

  always_comb begin
    ae   = MID_W'(a4_r);
    be5  = MID_W'(b4_r);
    ce   = MID_W'(c4_r);
    de   = MID_W'(d4_r);
    curv = (ae <<< 1) + ae + (be5 <<< 1);
    midv = (de <<< 3) + (ce <<< 2) + (be5 <<< 1) + ae;
    flat = (curv == '0) && (midv != '0);
    res_nxt.status = st4_r;
    res_nxt.last   = last4_r;
    if (st4_r != ST_OK) begin
      res_nxt.cubic  = '0;
      res_nxt.square = '0;
      res_nxt.linear = '0;
      res_nxt.konst  = '0;
      res_nxt.flat   = 1'b0;
    end else begin
      res_nxt.cubic  = flat ? '0 : a4_r;
      res_nxt.square = flat ? '0 : b4_r;
      res_nxt.linear = c4_r;
      res_nxt.konst  = d4_r;
      res_nxt.flat   = flat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_vld = vld_r[4];
  assign out_res = res_r;

endmodule
`default_nettype wire

// ===== sim/tb_monotone_cubic_spline_coeffs.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_monotone_cubic_spline_coeffs;
  import mcs_pkg::*;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct {
    word_t      xl, xr, yl, yr, sl, sr;
    logic       last;
  } interval_t;

  typedef struct {
    word_t      cubic, square, linear, konst;
    logic [1:0] status;
    logic       flat, last;
  } coeffs_t;

  localparam int NUM_RANDOM  = 1800;
  localparam int DRAIN_WAIT  = 200;
  localparam int STALL_LIMIT = 20000;

  class spline_scoreboard;
    coeffs_t pending[$];
    int      errors;
    int      checked;
    int      n_ok, n_notmono, n_degen, n_flat;

    static function longint floor_frac(longint v);
      return v >>> FRAC_BITS;
    endfunction

    static function longint clamp_word(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    static function bit same_sign(longint s, longint m);
      return s == 0 || ((s > 0) == (m > 0));
    endfunction

    static function longint ratio(longint s, longint m);
      longint q, one;
      one = longint'(1) <<< FRAC_BITS;
      q = (s * one) / m;
      if (q > 8 * one) q = 8 * one;
      return q;
    endfunction

    static function coeffs_t hermite_coeffs(interval_t iv);
      coeffs_t r;
      longint one, dx, dy, m, al, be, p0, p1, a, b, c, d;
      bit ok;
      one = longint'(1) <<< FRAC_BITS;
      dx = longint'(iv.xr) - longint'(iv.xl);
      dy = longint'(iv.yr) - longint'(iv.yl);
      m = 0;
      a = 0; b = 0; c = 0; d = 0;
      r.status = ST_OK;
      r.flat = 1'b0;
      r.last = iv.last;
      if (dx != 0) m = (dy * one) / dx;
      if (dx == 0 || m == 0) begin
        r.status = ST_DEGEN;
      end else begin
        ok = 1'b0;
        if (same_sign(iv.sl, m) && same_sign(iv.sr, m)) begin
          al = ratio(iv.sl, m);
          be = ratio(iv.sr, m);
          ok = (al + be - 2 * one <= 0) ||
               ((al + 2 * be - 2 * one > 0) &&
                ((2 * al + be - 3 * one <= 0) || (al + 2 * be - 3 * one <= 0) ||
                 (al * al + al * (be - 6 * one) + (be - 3 * one) * (be - 3 * one) < 0)));
        end
        if (!ok) begin
          r.status = ST_NOTMONO;
        end else begin
          p0 = floor_frac(dx * iv.sl);
          p1 = floor_frac(dx * iv.sr);
          a = clamp_word(p0 + p1 - 2 * dy);
          b = clamp_word(3 * dy - 2 * p0 - p1);
          c = clamp_word(p0);
          d = iv.yl;
          if (3 * a + 2 * b == 0 && 8 * d + 4 * c + 2 * b + a != 0) begin
            a = 0;
            b = 0;
            r.flat = 1'b1;
          end
        end
      end
      r.cubic = word_t'(a);
      r.square = word_t'(b);
      r.linear = word_t'(c);
      r.konst = word_t'(d);
      return r;
    endfunction

    function void note_interval(interval_t iv);
      coeffs_t r;
      r = hermite_coeffs(iv);
      pending.push_back(r);
      case (r.status)
        ST_OK:      n_ok++;
        ST_NOTMONO: n_notmono++;
        default:    n_degen++;
      endcase
      if (r.flat) n_flat++;
    endfunction

    function void check_result(coeffs_t act);
      coeffs_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction cubic=%h", $time, act.cubic);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.cubic !== e.cubic) begin
        $display("%0t: cubic exp %h got %h", $time, e.cubic, act.cubic); errors++;
      end
      if (act.square !== e.square) begin
        $display("%0t: square exp %h got %h", $time, e.square, act.square); errors++;
      end
      if (act.linear !== e.linear) begin
        $display("%0t: linear exp %h got %h", $time, e.linear, act.linear); errors++;
      end
      if (act.konst !== e.konst) begin
        $display("%0t: const exp %h got %h", $time, e.konst, act.konst); errors++;
      end
      if (act.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, act.status); errors++;
      end
      if (act.flat !== e.flat) begin
        $display("%0t: flattened exp %0b got %0b", $time, e.flat, act.flat); errors++;
      end
      if (act.last !== e.last) begin
        $display("%0t: last exp %0b got %0b", $time, e.last, act.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  word_t in_x_left = '0, in_x_right = '0, in_y_left = '0, in_y_right = '0;
  word_t in_slope_left = '0, in_slope_right = '0;
  logic in_last_interval = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  word_t out_coef_cubic, out_coef_square, out_coef_linear, out_coef_const;
  logic [1:0] out_status;
  logic out_flattened, out_last_out;

  int send_idle_pct = 25;
  int recv_idle_pct = 73;
  int quiet_cycles = 0;
  int sent = 0;
  spline_scoreboard sb = new();

  always #2 clk = ~clk;

  monotone_cubic_spline_coeffs dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        coeffs_t act;
        act.cubic = out_coef_cubic;
        act.square = out_coef_square;
        act.linear = out_coef_linear;
        act.konst = out_coef_const;
        act.status = out_status;
        act.flat = out_flattened;
        act.last = out_last_out;
        sb.check_result(act);
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_interval(interval_t iv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x_left <= iv.xl;
    in_x_right <= iv.xr;
    in_y_left <= iv.yl;
    in_y_right <= iv.yr;
    in_slope_left <= iv.sl;
    in_slope_right <= iv.sr;
    in_last_interval <= iv.last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_interval(iv);
    sent++;
  endtask

  function automatic interval_t make_iv(word_t xl, word_t xr, word_t yl, word_t yr,
                                        word_t sl, word_t sr, logic last);
    interval_t iv;
    iv.xl = xl; iv.xr = xr; iv.yl = yl; iv.yr = yr; iv.sl = sl; iv.sr = sr;
    iv.last = last;
    return iv;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(5))
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(4, 0)) <<< (FRAC_BITS - 2);
      2: return -(word_t'($urandom_range(400000)));
      3: return word_t'($urandom_range(400000));
      4: return word_t'(0);
      default: return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
    endcase
  endfunction

  // mostly well-formed intervals, not all monotone, with random scale and sign
  function automatic interval_t rand_interval();
    interval_t iv;
    longint dx, dy, m;
    if ($urandom_range(99) < 25) begin
      iv = make_iv(rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word(), 1'($urandom_range(1)));
      return iv;
    end
    dx = $urandom_range(1 << 20, 1);
    dy = $urandom_range(1 << 20, 1);
    if ($urandom_range(1)) dy = -dy;
    iv.xl = word_t'($urandom_range(1 << 24)) - (1 <<< 23);
    iv.xr = iv.xl + word_t'(dx);
    iv.yl = word_t'($urandom_range(1 << 24)) - (1 <<< 23);
    iv.yr = iv.yl + word_t'(dy);
    m = (dy <<< FRAC_BITS) / dx;
    iv.sl = word_t'((m * longint'($urandom_range(260))) / 64);
    iv.sr = word_t'((m * longint'($urandom_range(260))) / 64);
    if ($urandom_range(9) == 0) iv.sl = -iv.sl;
    iv.last = ($urandom_range(7) == 0);
    return iv;
  endfunction

  task automatic run_phase(int n, int s_pct, int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n) send_interval(rand_interval());
  endtask

  localparam word_t ONE = 1 <<< FRAC_BITS;
  localparam word_t MAXW = 32'sh7FFFFFFF;
  localparam word_t MINW = 32'sh80000000;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // directed: degenerate, zero slope, monotone, non-monotone, flat midpoint, extremes
    send_interval(make_iv(ONE, ONE, 0, ONE, ONE, ONE, 0));
    send_interval(make_iv(0, ONE, ONE, ONE, 0, 0, 1));
    send_interval(make_iv(0, ONE, 0, ONE, ONE, ONE, 0));
    send_interval(make_iv(0, ONE, 0, ONE, 0, 0, 0));
    send_interval(make_iv(0, ONE, 0, -ONE, -ONE, -ONE, 1));
    send_interval(make_iv(0, ONE, 0, ONE, -ONE, ONE, 0));
    send_interval(make_iv(0, ONE, 0, ONE, 4 * ONE, 4 * ONE, 0));
    send_interval(make_iv(0, ONE, 0, ONE, 3 * ONE, 0, 0));
    send_interval(make_iv(0, ONE, 0, ONE, 0, 3 * ONE, 0));
    send_interval(make_iv(0, ONE, 0, ONE, 2 * ONE, 2 * ONE, 0));
    send_interval(make_iv(0, ONE, 0, ONE, 8 * ONE, ONE, 0));
    send_interval(make_iv(0, ONE, ONE, 2 * ONE, 3 * ONE, 0, 0));
    send_interval(make_iv(0, ONE, 5 * ONE, 6 * ONE, 3 * ONE, 0, 1));
    send_interval(make_iv(MINW, MAXW, MINW, MAXW, MAXW, MAXW, 0));
    send_interval(make_iv(MAXW, MINW, MAXW, MINW, MINW, MINW, 1));
    send_interval(make_iv(MINW, MAXW, MAXW, MINW, MINW, 0, 0));
    send_interval(make_iv(0, MAXW, 0, 1, 0, 0, 0));
    send_interval(make_iv(MINW, MAXW, 0, 0, MAXW, MINW, 1));
    send_interval(make_iv(-1, -1, -1, -1, -1, -1, 1));
    send_interval(make_iv(0, 1, 0, MAXW, MAXW, MAXW, 0));
    send_interval(make_iv(0, 1, 0, MINW, MINW, 0, 0));
    run_phase(600, 25, 73);
    run_phase(600, 73, 25);
    run_phase(600, 0, 0);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d intervals, checked %0d results under three idle mixes.",
             sent, sb.checked);
    $display("Status mix: ok %0d, non-monotone %0d, degenerate %0d, flattened %0d.",
             sb.n_ok, sb.n_notmono, sb.n_degen, sb.n_flat);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
src/mcs_pkg.sv
src/mcs_front.sv
src/mcs_slope_div.sv
src/mcs_ratio_div.sv
src/mcs_eval.sv
src/monotone_cubic_spline_coeffs.sv
sim/tb_monotone_cubic_spline_coeffs.sv
